/* rtl/rtt_pkg.sv */
// ----------------------------------------------------------------------------
// RTT congestion detector package
// Shared types and constants for the top level and the testbench.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int unsigned Q_BITS      = 24;
    localparam int unsigned THR_BITS    = 32;
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam int unsigned QUO_STEPS   = 26;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROB_MIN      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROB_MAX      = 2'd2;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SCAN,
        ST_DECIDE,
        ST_DIVIDE,
        ST_COMPARE,
        ST_OUT
    } state_t;

endpackage

/* rtl/rtt_window_congestion_detector.sv */
// ----------------------------------------------------------------------------
// RTT window congestion detector
// Sliding-window maximum and running minimum RTT tracker with a probabilistic congestion check.
// ----------------------------------------------------------------------------
// Channel  | Direction | Contents
// s_axis   | in        | tdata: rtt_ns, random_fraction; tuser: operation
// m_axis   | out       | tdata: min_rtt_ns, max_rtt_ns; tuser: congested
// cfg      | in        | write enable, register index, 32-bit data
//
// A record is accepted, shifted into the cell row, rotated cell by cell past
// the maximum comparator, and then loaded into the output register.
// A check uses the 26-step serial scaled divider unless the decision is made
// at once, and then loads the output register.
// Reset is synchronous; the window needs no clearing pass.
// The next item is accepted while a result waits; a stalled output holds the
// finished item in its output state until the output register is free.
// ----------------------------------------------------------------------------
module rtt_window_congestion_detector #(
    parameter int unsigned WINDOW   = 30,
    parameter int unsigned RTT_BITS = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // rtt_ns [47:0], random_fraction [71:48]
    input  logic [0:0]  s_axis_tuser,   // operation [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // min_rtt_ns [47:0], max_rtt_ns [95:48]
    output logic [0:0]  m_axis_tuser,   // congested [0]
    input  logic        cfg_wr_en,
    input  logic [rtt_pkg::CFG_IDX_BITS-1:0] cfg_wr_index,
    input  logic [31:0] cfg_wr_data
);
    import rtt_pkg::*;

    // The counter serves both the scan and the divider, so it covers both.
    localparam int unsigned CNT_BITS = ($clog2(WINDOW + 1) > $clog2(QUO_STEPS))
                                       ? $clog2(WINDOW + 1) : $clog2(QUO_STEPS);
    localparam int unsigned WB       = RTT_BITS + 1;

    state_t state_reg, state_next;

    logic [THR_BITS-1:0] thr_reg;
    logic [Q_BITS-1:0]   pmin_reg, pmax_reg;

    logic [RTT_BITS-1:0] min_reg, min_next;
    logic [RTT_BITS-1:0] max_reg, max_next;
    logic [RTT_BITS-1:0] rtt_reg;
    logic [Q_BITS-1:0]   rnd_reg;
    logic [RTT_BITS-1:0] scan_max_reg, scan_max_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                cong_reg, cong_next;

    // Divider state: r < span; span, numerator and remainder are one bit wider than the RTT.
    logic [WB-1:0]       span_reg, span_next, num_reg, num_next;
    logic [WB-1:0]       rem_reg, rem_next;
    logic [QUO_STEPS-1:0] quo_reg, quo_next;
    logic [QUO_STEPS-1:0] a_reg, a_next;
    logic                inv_reg, inv_next;

    logic out_valid_reg;
    logic [RTT_BITS-1:0] out_min_reg, out_max_reg;
    logic out_cong_reg;
    logic out_load;

    // Cell row.
    logic                shift_en;
    logic [RTT_BITS-1:0] head_data;
    logic                head_valid;
    logic [RTT_BITS-1:0] cdata [WINDOW+1];
    logic                cvalid [WINDOW+1];

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            rtt_cell #(.RTT_BITS(RTT_BITS)) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .shift_en  (shift_en),
                .data_in   (cdata[g]),
                .valid_in  (cvalid[g]),
                .data_out  (cdata[g+1]),
                .valid_out (cvalid[g+1])
            );
        end
    endgenerate

    // Entry zero is the newest sample; the last cell drops the oldest on a
    // record and feeds back to the head while the row rotates.
    assign cdata[0]  = head_data;
    assign cvalid[0] = head_valid;

    logic accept;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= THR_BITS'(5000000);
            pmin_reg <= Q_BITS'(168);
            pmax_reg <= Q_BITS'(8388608);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_MIN_THRESHOLD: thr_reg  <= cfg_wr_data;
                CFG_PROB_MIN:      pmin_reg <= cfg_wr_data[Q_BITS-1:0];
                CFG_PROB_MAX:      pmax_reg <= cfg_wr_data[Q_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Datapath helpers.
    logic [WB-1:0] lo_w, rtt_w, max_w, min_w;
    logic [WB-1:0] dbl_sub, rem_a, add_sub, rem_b;
    logic          dbl_ge, add_ge;
    logic [Q_BITS:0] prob;

    always_comb begin
        rtt_w = {1'b0, rtt_reg};
        max_w = {1'b0, max_reg};
        min_w = {1'b0, min_reg};
        lo_w  = min_w + WB'(thr_reg);
        dbl_sub = span_reg - rem_reg;
        dbl_ge  = rem_reg >= dbl_sub;
        rem_a   = dbl_ge ? (rem_reg - dbl_sub) : (rem_reg + rem_reg);
        add_sub = span_reg - num_reg;
        add_ge  = rem_a >= add_sub;
        rem_b   = a_reg[QUO_STEPS-1] ? (add_ge ? (rem_a - add_sub) : (rem_a + num_reg))
                                     : rem_a;
        if (inv_reg) begin
            prob = {1'b0, pmin_reg} - (Q_BITS+1)'(quo_reg);
        end else begin
            prob = {1'b0, pmin_reg} + (Q_BITS+1)'(quo_reg);
        end
    end

    always_comb begin
        state_next    = state_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        scan_max_next = scan_max_reg;
        cnt_next      = cnt_reg;
        cong_next     = cong_reg;
        span_next     = span_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        a_next        = a_reg;
        inv_next      = inv_reg;
        shift_en      = 1'b0;
        head_data     = cdata[WINDOW];
        head_valid    = cvalid[WINDOW];
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cong_next = 1'b0;
                    state_next = (s_axis_tuser[0] == OP_RECORD) ? ST_SHIFT : ST_DECIDE;
                end
            end
            ST_SHIFT: begin
                shift_en   = 1'b1;
                head_data  = rtt_reg;
                head_valid = 1'b1;
                if (rtt_reg < min_reg) begin
                    min_next = rtt_reg;
                end
                scan_max_next = '0;
                cnt_next      = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                shift_en = 1'b1;
                if (cvalid[WINDOW] && cdata[WINDOW] > scan_max_reg) begin
                    scan_max_next = cdata[WINDOW];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WINDOW - 1)) begin
                    max_next   = scan_max_next;
                    state_next = ST_OUT;
                end
            end
            ST_DECIDE: begin
                span_next = max_w - lo_w;
                num_next  = rtt_w - lo_w;
                rem_next  = '0;
                quo_next  = '0;
                inv_next  = pmax_reg < pmin_reg;
                a_next    = QUO_STEPS'(inv_next ? (pmin_reg - pmax_reg)
                                                : (pmax_reg - pmin_reg));
                cnt_next  = '0;
                if (rtt_w < lo_w) begin
                    cong_next  = 1'b0;
                    state_next = ST_OUT;
                end else if (rtt_reg > max_reg) begin
                    cong_next  = 1'b1;
                    state_next = ST_OUT;
                end else if (max_w == lo_w) begin
                    cong_next  = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                rem_next = rem_b;
                quo_next = {quo_reg[QUO_STEPS-2:0], 1'b0}
                         + QUO_STEPS'(dbl_ge)
                         + QUO_STEPS'(a_reg[QUO_STEPS-1] && add_ge);
                a_next   = {a_reg[QUO_STEPS-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(QUO_STEPS - 1)) begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                cong_next  = {1'b0, rnd_reg} < prob;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            min_reg       <= '1;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rtt_reg <= RTT_BITS'(s_axis_tdata[47:0]);
            rnd_reg <= s_axis_tdata[71:48];
        end
        scan_max_reg <= scan_max_next;
        cnt_reg      <= cnt_next;
        cong_reg     <= cong_next;
        span_reg     <= span_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        a_reg        <= a_next;
        inv_reg      <= inv_next;
        if (out_load) begin
            out_cong_reg <= cong_reg;
            out_min_reg  <= min_reg;
            out_max_reg  <= max_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_cong_reg;
    assign m_axis_tdata  = {48'(out_max_reg), 48'(out_min_reg)};

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (state_reg == ST_IDLE))
        else $error("ready raised while busy");
    a_min_falls: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |=> (min_reg <= $past(min_reg)))
        else $error("minimum rose on a record");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    a_max_only_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVIDE) |=> $stable(max_reg))
        else $error("maximum changed during a check");
`endif

endmodule

/* rtl/rtt_cell.sv */
// ----------------------------------------------------------------------------
// RTT window cell
// Holds one window sample; the row shifts on a record and rotates during the
// maximum scan, handing each sample to its neighbour.
// ----------------------------------------------------------------------------
module rtt_cell #(
    parameter int unsigned RTT_BITS = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic [RTT_BITS-1:0] data_in,
    input  logic                valid_in,
    output logic [RTT_BITS-1:0] data_out,
    output logic                valid_out
);

    logic [RTT_BITS-1:0] data_reg;
    logic                valid_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= valid_in;
        end
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// RTT window congestion detector testbench
// Drives record and check items with random bursts and receiver stalls,
// predicts each result from a behavioural model of the window and the
// marking probability, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rtt_pkg::*;

    localparam int WIN = 30;
    localparam logic [47:0] RTT_ONES = {48{1'b1}};

    typedef struct packed {
        logic        op;
        logic [47:0] rtt;
        logic [23:0] rnd;
    } rtt_item_t;

    typedef struct packed {
        logic        congested;
        logic [47:0] min_rtt;
        logic [47:0] max_rtt;
    } rtt_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // rtt_ns [47:0], random_fraction [71:48]
    logic [0:0]  s_axis_tuser = '0;   // operation [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // min_rtt_ns [47:0], max_rtt_ns [95:48]
    logic [0:0]  m_axis_tuser;        // congested [0]
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_wr_index = '0;
    logic [31:0] cfg_wr_data = '0;

    rtt_window_congestion_detector u_dut (.*);

    always #6 aclk = ~aclk;

    // Predictor state.
    logic [31:0] thr_ns;
    logic [23:0] pmin_q, pmax_q;
    logic [47:0] win_rtt [WIN];
    int          win_cnt, win_ptr;
    logic [47:0] min_rtt_p, max_rtt_p;

    rtt_item_t   pending_items[$];
    rtt_result_t expected_results[$];
    int          n_fail = 0, n_out = 0, n_sent = 0, n_congested = 0;
    bit          hold_off = 1'b0, sender_pause = 1'b0;

    function automatic void queue_item(rtt_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic logic marking_decision(logic [47:0] rtt, logic [23:0] rnd);
        logic [48:0] lo, span, num;
        logic [24:0] delta;
        logic [75:0] quo;
        logic [24:0] prob;
        if (rtt < min_rtt_p) return 1'b0;
        if (rtt - min_rtt_p < {16'd0, thr_ns}) return 1'b0;
        if (rtt > max_rtt_p) return 1'b1;
        lo = {1'b0, min_rtt_p} + thr_ns;
        span = {1'b0, max_rtt_p} - lo;
        if (span == 0) return 1'b0;
        num = {1'b0, rtt} - lo;
        delta = (pmax_q >= pmin_q) ? pmax_q - pmin_q : pmin_q - pmax_q;
        quo = (76'(delta) * 76'(num)) / 76'(span);
        prob = (pmax_q >= pmin_q) ? pmin_q + 25'(quo) : pmin_q - 25'(quo);
        return {1'b0, rnd} < prob;
    endfunction

    function automatic rtt_result_t predict_result(rtt_item_t it);
        rtt_result_t r;
        logic [47:0] mx;
        r.congested = 1'b0;
        if (it.op == OP_RECORD) begin
            win_rtt[win_ptr] = it.rtt;
            win_ptr = (win_ptr + 1 >= WIN) ? 0 : win_ptr + 1;
            if (win_cnt < WIN) win_cnt++;
            if (it.rtt < min_rtt_p) min_rtt_p = it.rtt;
            mx = '0;
            for (int i = 0; i < win_cnt; i++) if (win_rtt[i] > mx) mx = win_rtt[i];
            max_rtt_p = mx;
        end else begin
            r.congested = marking_decision(it.rtt, it.rnd);
        end
        r.min_rtt = min_rtt_p;
        r.max_rtt = max_rtt_p;
        return r;
    endfunction

    // Sender: bursts of random length with random gaps.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        rtt_item_t it;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                it = pending_items[0];
                pending_items.delete(0);
                expected_results = {expected_results, predict_result(it)};
                n_sent++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0 && !sender_pause) begin
                    it = pending_items[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {it.rnd, it.rtt};
                    s_axis_tuser  <= it.op;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls on its own pattern, plus a long forced hold-off.
    int stall_phase = 0;
    always @(posedge aclk) begin
        rtt_result_t got, want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata[47:0], m_axis_tdata[95:48]};
                n_out++;
                if (got.congested) n_congested++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    n_fail++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (got.congested !== want.congested) begin
                        $display("%0t: congested expected %0b actual %0b",
                                 $time, want.congested, got.congested);
                        n_fail++;
                    end
                    if (got.min_rtt !== want.min_rtt) begin
                        $display("%0t: min_rtt expected %h actual %h",
                                 $time, want.min_rtt, got.min_rtt);
                        n_fail++;
                    end
                    if (got.max_rtt !== want.max_rtt) begin
                        $display("%0t: max_rtt expected %h actual %h",
                                 $time, want.max_rtt, got.max_rtt);
                        n_fail++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 23;
            m_axis_tready <= !hold_off && (stall_phase < 15 ? 1'b1 : ($urandom_range(0, 3) != 0));
        end
    end

    function automatic logic [47:0] random_rtt();
        case ($urandom_range(0, 5))
            0: return 48'({$urandom, $urandom});
            1: return 48'($urandom_range(0, 20));
            default: return 48'd1000000 + 48'($urandom_range(0, 30000000));
        endcase
    endfunction

    function automatic rtt_item_t make_item(logic op, logic [47:0] rtt, logic [23:0] rnd);
        rtt_item_t it;
        it.op = op;
        it.rtt = rtt;
        it.rnd = rnd;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MIN_THRESHOLD: thr_ns = val;
            CFG_PROB_MIN:      pmin_q = val[23:0];
            CFG_PROB_MAX:      pmax_q = val[23:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            queue_item(make_item(1'($urandom_range(0, 1)), random_rtt(), 24'($urandom)));
    endtask

    initial begin
        thr_ns = 32'd5000000; pmin_q = 24'd168; pmax_q = 24'd8388608;
        win_cnt = 0; win_ptr = 0; min_rtt_p = RTT_ONES; max_rtt_p = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: check before any record, extremes, threshold edges.
        queue_item(make_item(OP_CHECK, RTT_ONES, 24'h0));
        queue_item(make_item(OP_CHECK, 48'd0, 24'hFFFFFF));
        queue_item(make_item(OP_RECORD, 48'd1000, 24'hFFFFFF));
        queue_item(make_item(OP_RECORD, 48'd1000, 24'h0));
        queue_item(make_item(OP_CHECK, 48'd5001000, 24'h0));
        queue_item(make_item(OP_CHECK, 48'd0, 24'h0));
        queue_item(make_item(OP_RECORD, 48'd20000000, 24'h0));
        queue_item(make_item(OP_CHECK, 48'd10000000, 24'h000100));
        queue_item(make_item(OP_CHECK, 48'd10000000, 24'hFFFFFF));
        queue_item(make_item(OP_CHECK, 48'd20000001, 24'hFFFFFF));
        queue_item(make_item(OP_CHECK, 48'd20000000, 24'h7FFFFF));
        queue_item(make_item(OP_RECORD, RTT_ONES, 24'h0));
        queue_item(make_item(OP_CHECK, RTT_ONES, 24'h0));
        queue_item(make_item(OP_RECORD, 48'd0, 24'h0));
        queue_item(make_item(OP_CHECK, 48'd4999999, 24'h0));
        queue_item(make_item(OP_CHECK, 48'd5000000, 24'h0));
        for (int i = 0; i < 8; i++)
            queue_item(make_item(OP_RECORD, 48'd3000000 + 48'(i), 24'h0));
        wait_drained();

        // Zero threshold, with a check at zero RTT.
        write_reg(CFG_MIN_THRESHOLD, 32'd0);
        queue_item(make_item(OP_CHECK, 48'd0, 24'h0));
        random_phase(250);
        wait_drained();

        // Inverted probabilities and the widest threshold.
        write_reg(CFG_PROB_MIN, 32'hFFFFFFFF);
        write_reg(CFG_PROB_MAX, 32'd0);
        write_reg(CFG_MIN_THRESHOLD, 32'hFFFFFFFF);
        random_phase(200);
        wait_drained();

        // Small threshold, full probability range; long receiver hold-off.
        write_reg(CFG_MIN_THRESHOLD, 32'd1000);
        write_reg(CFG_PROB_MIN, 32'd0);
        write_reg(CFG_PROB_MAX, 32'hFFFFFF);
        hold_off = 1'b1;
        random_phase(300);
        repeat (400) @(posedge aclk);
        hold_off = 1'b0;
        wait_drained();

        // Sender pauses until everything has come back, then resumes.
        write_reg(CFG_MIN_THRESHOLD, 32'($urandom_range(0, 20000000)));
        write_reg(CFG_PROB_MIN, 32'($urandom));
        write_reg(CFG_PROB_MAX, 32'($urandom));
        random_phase(140);
        repeat (300) @(posedge aclk);
        sender_pause = 1'b1;
        while (s_axis_tvalid || expected_results.size() != 0) @(posedge aclk);
        sender_pause = 1'b0;
        random_phase(140);
        wait_drained();

        $display("Covered %0d items, %0d results, %0d congested, over five settings.",
                 n_sent, n_out, n_congested);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(12ns * 400000);
        $display("Simulation FAILED");
        $finish;
    end
endmodule
